>>> sv/lcd_window_write_controller_core_defines.svh
// assertion macros for the lcd window write controller
// expects signals clk and arst_n in the including module
`ifndef LCD_WINDOW_WRITE_CONTROLLER_CORE_DEFINES_SVH
`define LCD_WINDOW_WRITE_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define LCDWWC_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("lcdwwc check failed");
// property that must hold in the cycle after a trigger
`define LCDWWC_ASSERT_NEXT(label, trig, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
	else $error("lcdwwc check failed");
`else
`define LCDWWC_ASSERT_ALWAYS(label, expr)
`define LCDWWC_ASSERT_NEXT(label, trig, expr)
`endif

`endif

>>> sv/lcdwwc_pkg.sv
// types and constants of the lcd window write controller
// no dependencies; used by the channel interfaces and the core
`default_nettype none

package lcdwwc_pkg;

	// panel geometry and framebuffer addressing
	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 128;
	localparam int ROW_SHIFT    = 8;
	localparam int ADDRESS_BITS = 15;

	localparam int MEM_ADDR_W = 15;
	localparam int SUM_W      = (8 + ROW_SHIFT + 1 > MEM_ADDR_W + 1) ?
		(8 + ROW_SHIFT + 1) : (MEM_ADDR_W + 1);
	localparam int MASK_BITS  = (ADDRESS_BITS < SUM_W) ? ADDRESS_BITS : SUM_W;
	localparam logic [SUM_W-1:0] ADDR_MASK = SUM_W'((64'd1 << MASK_BITS) - 64'd1);

	// command codes
	localparam logic [7:0] OP_NONE         = 8'h00;
	localparam logic [7:0] OP_COLUMN_SET   = 8'h2A;
	localparam logic [7:0] OP_ROW_SET      = 8'h2B;
	localparam logic [7:0] OP_MEMORY_WRITE = 8'h2C;

	// window limits
	localparam logic [7:0] COLUMN_CAP = 8'h83;
	localparam logic [7:0] ROW_CAP    = 8'hA1;
	localparam logic [7:0] COLUMN_END_RESET = 8'(PANEL_WIDTH - 1);
	localparam logic [7:0] ROW_END_RESET    = 8'(PANEL_HEIGHT - 1);

	// parameter-byte positions that carry window start and end
	localparam logic [8:0] POS_START    = 9'd1;
	localparam logic [8:0] POS_END      = 9'd3;
	localparam logic [8:0] POSITION_MAX = 9'd511;

	typedef struct packed {
		logic       chip_select_n;
		logic       write_strobe;
		logic       data_not_command;
		logic [7:0] bus_byte;
		logic       clear_repaint;
		logic       clear_frame_count;
	} pins_t;

	typedef struct packed {
		logic                  mem_write;
		logic [MEM_ADDR_W-1:0] mem_address;
		logic [7:0]            mem_byte;
		logic                  repaint_pending;
		logic [31:0]           frame_count;
		logic                  bus_drive;
	} result_t;

endpackage

`default_nettype wire

>>> sv/lcdwwc_if.sv
// valid/ready channel interfaces for bus samples and results
// depends on lcdwwc_pkg for the payload types
`default_nettype none

interface lcdwwc_pins_if;
	logic                valid;
	logic                ready;
	lcdwwc_pkg::pins_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lcdwwc_result_if;
	logic                valid;
	logic                ready;
	lcdwwc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/lcd_window_write_controller_core.sv
// lcd window write controller: 8080-style bus decoder to framebuffer byte writes
// Sustained rate is one bus sample per clock while the result sink keeps taking results. Each
// sample passes an input register, then the decode and window stepping logic updates the
// controller state and fills the result register, from which it leaves when the sink takes it.
// While a result waits, the input register still takes one more item, then the input stalls
// until the result sink takes the result; the only stall comes from the sink.
// A rising write strobe with chip select low latches a command or a data byte. Column-set and
// row-set take start from parameter byte 1 and end from byte 3 (capped at 131 and 161),
// memory-write rewinds to the window start and counts a frame, and data after memory-write
// becomes framebuffer writes that walk the window. Repaint flag and frame count are reported
// on every result and cleared on request after reporting. The bus is never driven.
// depends on lcdwwc_pkg, lcdwwc_if and lcd_window_write_controller_core_defines.svh
`default_nettype none
`include "lcd_window_write_controller_core_defines.svh"

module lcd_window_write_controller_core (
	input  wire              clk,
	input  wire              arst_n,
	lcdwwc_pins_if.sink      pins,
	lcdwwc_result_if.source  result
);

	// input stage
	logic                 valid_s1;
	lcdwwc_pkg::pins_t    item_s1;

	// result stage
	logic                 res_valid_q;
	lcdwwc_pkg::result_t  res_q;

	// controller state
	logic        last_strobe_q;
	logic [7:0]  active_cmd_q;
	logic [8:0]  byte_pos_q;
	logic [7:0]  col_start_q;
	logic [7:0]  col_end_q;
	logic [7:0]  row_start_q;
	logic [7:0]  row_end_q;
	logic [7:0]  cur_row_q;
	logic        repaint_q;
	logic [31:0] frame_cnt_q;

	// next-state values after this sample's bus action
	logic [7:0]  active_cmd_n;
	logic [8:0]  byte_pos_n;
	logic [7:0]  col_start_n;
	logic [7:0]  col_end_n;
	logic [7:0]  row_start_n;
	logic [7:0]  row_end_n;
	logic [7:0]  cur_row_n;
	logic        repaint_n;
	logic [31:0] frame_cnt_n;

	logic        strobe_edge;
	logic        wr;
	logic [lcdwwc_pkg::MEM_ADDR_W-1:0] addr;
	logic [7:0]  wbyte;
	logic [8:0]  pos_step;
	logic [7:0]  row_inc;
	logic [7:0]  cap_val;
	logic [lcdwwc_pkg::SUM_W-1:0] addr_sum;

	logic advance;
	logic take_s1;

	function automatic logic [7:0] cap_at(input logic [7:0] v, input logic [7:0] top);
		return (v > top) ? top : v;
	endfunction

	// the result register frees up when empty or being taken
	assign advance     = !res_valid_q || result.ready;
	assign take_s1     = valid_s1 && advance;
	assign pins.ready  = !valid_s1 || advance;

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// saturating byte counter and framebuffer address
	assign pos_step = (byte_pos_q == lcdwwc_pkg::POSITION_MAX) ? byte_pos_q
		: byte_pos_q + 9'd1;
	assign row_inc  = cur_row_q + 8'd1;
	assign addr_sum = ((lcdwwc_pkg::SUM_W'(cur_row_q) << lcdwwc_pkg::ROW_SHIFT)
		+ lcdwwc_pkg::SUM_W'(byte_pos_q)) & lcdwwc_pkg::ADDR_MASK;

	assign strobe_edge = !item_s1.chip_select_n && item_s1.write_strobe && !last_strobe_q;

	always_comb begin
		active_cmd_n = active_cmd_q;
		byte_pos_n   = byte_pos_q;
		col_start_n  = col_start_q;
		col_end_n    = col_end_q;
		row_start_n  = row_start_q;
		row_end_n    = row_end_q;
		cur_row_n    = cur_row_q;
		repaint_n    = repaint_q;
		frame_cnt_n  = frame_cnt_q;
		wr           = 1'b0;
		addr         = '0;
		wbyte        = '0;
		cap_val      = (active_cmd_q == lcdwwc_pkg::OP_COLUMN_SET) ? lcdwwc_pkg::COLUMN_CAP
			: lcdwwc_pkg::ROW_CAP;

		if (strobe_edge) begin
			if (!item_s1.data_not_command) begin
				// new command: parameter bytes count from zero; memory-write starts at the window start
				active_cmd_n = item_s1.bus_byte;
				byte_pos_n   = '0;
				if (item_s1.bus_byte == lcdwwc_pkg::OP_MEMORY_WRITE) begin
					cur_row_n   = row_start_q;
					byte_pos_n  = {col_start_q, 1'b0};
					frame_cnt_n = frame_cnt_q + 32'd1;
				end
			end else if (active_cmd_q == lcdwwc_pkg::OP_COLUMN_SET
				|| active_cmd_q == lcdwwc_pkg::OP_ROW_SET) begin
				// window parameters; high bytes only move the counter
				if (byte_pos_q == lcdwwc_pkg::POS_START) begin
					if (active_cmd_q == lcdwwc_pkg::OP_COLUMN_SET)
						col_start_n = cap_at(item_s1.bus_byte, cap_val);
					else
						row_start_n = cap_at(item_s1.bus_byte, cap_val);
				end else if (byte_pos_q == lcdwwc_pkg::POS_END) begin
					if (active_cmd_q == lcdwwc_pkg::OP_COLUMN_SET)
						col_end_n = cap_at(item_s1.bus_byte, cap_val);
					else
						row_end_n = cap_at(item_s1.bus_byte, cap_val);
				end
				byte_pos_n = pos_step;
			end else if (active_cmd_q == lcdwwc_pkg::OP_MEMORY_WRITE) begin
				// pixel byte: write, then step through the window
				wr         = 1'b1;
				addr       = addr_sum[lcdwwc_pkg::MEM_ADDR_W-1:0];
				wbyte      = item_s1.bus_byte;
				repaint_n  = 1'b1;
				byte_pos_n = pos_step;
				// past the last byte of the row (two bytes per column)
				if (pos_step > {col_end_q, 1'b1}) begin
					byte_pos_n = {col_start_q, 1'b0};
					cur_row_n  = (row_inc > row_end_q) ? row_start_q : row_inc;
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pins.ready) begin
			valid_s1 <= pins.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pins.valid && pins.ready) begin
			item_s1 <= pins.data;
		end
	end

	// controller state moves once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_strobe_q <= 1'b0;
			active_cmd_q  <= lcdwwc_pkg::OP_NONE;
			byte_pos_q    <= '0;
			col_start_q   <= '0;
			col_end_q     <= lcdwwc_pkg::COLUMN_END_RESET;
			row_start_q   <= '0;
			row_end_q     <= lcdwwc_pkg::ROW_END_RESET;
			cur_row_q     <= '0;
			repaint_q     <= 1'b1;
			frame_cnt_q   <= '0;
		end else if (take_s1) begin
			last_strobe_q <= item_s1.write_strobe;
			active_cmd_q  <= active_cmd_n;
			byte_pos_q    <= byte_pos_n;
			col_start_q   <= col_start_n;
			col_end_q     <= col_end_n;
			row_start_q   <= row_start_n;
			row_end_q     <= row_end_n;
			cur_row_q     <= cur_row_n;
			// clear-on-read after reporting
			repaint_q     <= item_s1.clear_repaint ? 1'b0 : repaint_n;
			frame_cnt_q   <= item_s1.clear_frame_count ? 32'd0 : frame_cnt_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			res_q.mem_write       <= wr;
			res_q.mem_address     <= addr;
			res_q.mem_byte        <= wbyte;
			res_q.repaint_pending <= repaint_n;
			res_q.frame_count     <= frame_cnt_n;
			res_q.bus_drive       <= 1'b0;
		end
	end

	// checks
	`LCDWWC_ASSERT_ALWAYS(a_idle_write_zero,
		!res_valid_q || res_q.mem_write
		|| (res_q.mem_address == '0 && res_q.mem_byte == '0))
	`LCDWWC_ASSERT_ALWAYS(a_col_capped,
		col_start_q <= lcdwwc_pkg::COLUMN_CAP && col_end_q <= lcdwwc_pkg::COLUMN_CAP)
	`LCDWWC_ASSERT_NEXT(a_frame_step, take_s1 && !item_s1.clear_frame_count,
		frame_cnt_q == $past(frame_cnt_q) || frame_cnt_q == $past(frame_cnt_q) + 32'd1)
	`LCDWWC_ASSERT_NEXT(a_write_sets_repaint, take_s1 && wr,
		res_valid_q && res_q.repaint_pending)

endmodule

`default_nettype wire
